[sv/bounded_string_escaper_defines.svh]
// assertion macros shared by the escaper rtl
`ifndef BOUNDED_STRING_ESCAPER_DEFINES_SVH
`define BOUNDED_STRING_ESCAPER_DEFINES_SVH
`ifndef ASSERT_OFF
// checked property, disabled while reset is asserted
`define BSE_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("bse assertion failed");
// checked property that also holds during reset
`define BSE_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("bse assertion failed");
`else
`define BSE_ASSERT(lbl, clk, rst_n, prop)
`define BSE_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

[sv/bse_pkg.sv]
// types, constants and helper functions of the string escaper
`timescale 1ns / 1ps
package bse_pkg;

  // input modes
  localparam logic [1:0] MODE_BYTE = 2'd0;
  localparam logic [1:0] MODE_END  = 2'd1;
  localparam logic [1:0] MODE_NULL = 2'd2;

  // characters
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_LOW_N  = 8'h6e;
  localparam logic [7:0] CH_LOW_R  = 8'h72;
  localparam logic [7:0] CH_LOW_T  = 8'h74;
  localparam logic [7:0] CH_LOW_X  = 8'h78;
  localparam logic [7:0] CTRL_LIMIT = 8'h20;
  localparam logic [7:0] CH_DEL     = 8'h7f;

  localparam logic [15:0] MIN_CAP  = 16'd3;
  localparam logic [15:0] FULL_NULL_CAP = 16'd9;
  localparam logic [2:0]  NULL_LEN = 3'd6;

  // what the back end has to emit for one queued command
  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_PLAIN,
    ACT_PAIR,
    ACT_HEX,
    ACT_END,
    ACT_NULLSTR,
    ACT_NUL,
    ACT_EMPTY
  } act_e;

  typedef struct packed {
    logic       open;      // opening quote goes out first
    act_e       act;
    logic [7:0] data;      // plain byte, escape letter or byte to hex
    logic [2:0] null_len;  // chars of (null) that fit
  } cmd_t;

  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    logic [7:0] r;
    if (nib < 4'd10) begin
      r = 8'h30 + {4'd0, nib};
    end else begin
      r = 8'h57 + {4'd0, nib};
    end
    return r;
  endfunction

  function automatic logic [7:0] null_char(input logic [2:0] idx);
    logic [7:0] r;
    case (idx)
      3'd0: r = 8'h28;
      3'd1: r = 8'h6e;
      3'd2: r = 8'h75;
      3'd3: r = 8'h6c;
      3'd4: r = 8'h6c;
      3'd5: r = 8'h29;
      default: r = CH_NUL;
    endcase
    return r;
  endfunction

endpackage

[sv/bounded_string_escaper.sv]
// top level of the bounded string escaper: front, command queue and back
//
//  channel   direction  handshake            payload
//  input     in         push / full          mode_i, in_byte_i
//  result    out        pop / empty          out_byte_o, is_last_o, nothing_written_o
//  config    in         cfg_we_i             cfg_wdata_i (out_capacity)
//
// the front takes one item per cycle while the command queue has room.
// the back emits one result byte per cycle while the reader keeps up, so a string
// byte becomes 1 to 4 bytes (one more with the opening quote) and a null marker up
// to 9. the output register frees each cycle it is popped; a stalled reader backs
// up into the queue and then raises full. reset clears the control state and sets
// the capacity to 0; data registers are not reset, and there is no clearing pass.
`timescale 1ns / 1ps
module bounded_string_escaper #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  mode_i,
  input  logic [7:0]  in_byte_i,
  input  logic        pop,
  output logic        empty,
  output logic [7:0]  out_byte_o,
  output logic        is_last_o,
  output logic        nothing_written_o
);

  bse_pkg::cmd_t front_cmd, back_cmd;
  logic          cmd_push, cmd_pop, cmd_valid;

  bse_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .push_i      (push),
    .mode_i      (mode_i),
    .in_byte_i   (in_byte_i),
    .q_full_i    (full),
    .cmd_push_o  (cmd_push),
    .cmd_o       (front_cmd)
  );

  bse_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .wdata_i (front_cmd),
    .full_o  (full),
    .pop_i   (cmd_pop),
    .valid_o (cmd_valid),
    .rdata_o (back_cmd)
  );

  bse_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_valid_i       (cmd_valid),
    .cmd_i             (back_cmd),
    .cmd_pop_o         (cmd_pop),
    .out_pop_i         (pop),
    .out_empty_o       (empty),
    .out_byte_o        (out_byte_o),
    .is_last_o         (is_last_o),
    .nothing_written_o (nothing_written_o)
  );

endmodule

[sv/bse_fifo.sv]
// small command queue between the classifying front and the emitting back
`timescale 1ns / 1ps
`include "bounded_string_escaper_defines.svh"
module bse_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  bse_pkg::cmd_t wdata_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output bse_pkg::cmd_t rdata_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  bse_pkg::cmd_t mem_q [DEPTH];
  logic [PtrW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic wr, rd;

  assign full_o  = (count_q == CntW'(DEPTH));
  assign valid_o = (count_q != '0);
  assign wr      = push_i && !full_o;
  assign rd      = pop_i && valid_o;
  assign rdata_o = mem_q[rptr_q];

  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (wr) begin
      wptr_d = (wptr_q == PtrW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (rd) begin
      rptr_d = (rptr_q == PtrW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (wr && !rd) begin
      count_d = count_q + 1'b1;
    end else if (rd && !wr) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  `BSE_ASSERT_ALWAYS(a_count_bound, clk_i, !rst_ni || count_q <= CntW'(DEPTH))
  `BSE_ASSERT(a_count_up, clk_i, rst_ni, wr && !rd |=> count_q == $past(count_q) + 1'b1)
  `BSE_ASSERT(a_count_down, clk_i, rst_ni, rd && !wr |=> count_q == $past(count_q) - 1'b1)

endmodule

[sv/bse_front.sv]
// front end: capacity register, budget bookkeeping and item classification
`timescale 1ns / 1ps
module bse_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [15:0]   cfg_wdata_i,
  input  logic          push_i,
  input  logic [1:0]    mode_i,
  input  logic [7:0]    in_byte_i,
  input  logic          q_full_i,
  output logic          cmd_push_o,
  output bse_pkg::cmd_t cmd_o
);

  logic [15:0] cap_q;
  logic [15:0] w_q, w_d;
  logic        open_q, open_d;
  logic        trunc_q, trunc_d;

  logic        accept;
  logic        emit;
  logic        cap_ok;
  logic        open_new;
  logic [15:0] w_base;
  logic [16:0] w17, cap17;
  logic [2:0]  len;
  logic        special;
  logic [7:0]  esc_char;
  logic        ctrl;

  assign accept = push_i && !q_full_i;
  assign cap_ok = (cap_q >= bse_pkg::MIN_CAP);

  // escape pairs and their letters
  always_comb begin
    special  = 1'b1;
    esc_char = in_byte_i;
    case (in_byte_i)
      bse_pkg::CH_LF:     esc_char = bse_pkg::CH_LOW_N;
      bse_pkg::CH_TAB:    esc_char = bse_pkg::CH_LOW_T;
      bse_pkg::CH_CR:     esc_char = bse_pkg::CH_LOW_R;
      bse_pkg::CH_BSLASH: esc_char = in_byte_i;
      bse_pkg::CH_QUOTE:  esc_char = in_byte_i;
      default:            special  = 1'b0;
    endcase
  end

  assign ctrl = (in_byte_i < bse_pkg::CTRL_LIMIT) || (in_byte_i >= bse_pkg::CH_DEL);

  always_comb begin
    cmd_o    = '{open: 1'b0, act: bse_pkg::ACT_NONE, data: in_byte_i, null_len: 3'd0};
    emit     = 1'b0;
    len      = 3'd0;
    w_d      = w_q;
    open_d   = open_q;
    trunc_d  = trunc_q;
    open_new = !open_q && cap_ok;
    // the opening quote counts before the byte's own budget test
    w_base   = open_new ? 16'd1 : w_q;
    w17      = {1'b0, w_base};
    cap17    = {1'b0, cap_q};
    case (mode_i)
      bse_pkg::MODE_BYTE: begin
        cmd_o.open = open_new;
        if (cap_ok && !trunc_q) begin
          if (!(w17 + 17'd2 < cap17)) begin
            trunc_d = 1'b1;
          end else if (special) begin
            if (w17 + 17'd3 < cap17) begin
              cmd_o.act  = bse_pkg::ACT_PAIR;
              cmd_o.data = esc_char;
              len        = 3'd2;
            end else begin
              trunc_d = 1'b1;
            end
          end else if (ctrl) begin
            if (w17 + 17'd5 < cap17) begin
              cmd_o.act = bse_pkg::ACT_HEX;
              len       = 3'd4;
            end else begin
              trunc_d = 1'b1;
            end
          end else begin
            cmd_o.act = bse_pkg::ACT_PLAIN;
            len       = 3'd1;
          end
        end
        open_d = open_q | open_new;
        w_d    = w_base + 16'(len);
        emit   = open_new || (cmd_o.act != bse_pkg::ACT_NONE);
      end
      bse_pkg::MODE_END, bse_pkg::MODE_NULL: begin
        emit = 1'b1;
        if (!open_q && cap_q == 16'd0) begin
          cmd_o.act = bse_pkg::ACT_EMPTY;
        end else if (!open_q && !cap_ok) begin
          cmd_o.act = bse_pkg::ACT_NUL;
        end else begin
          cmd_o.open = !open_q;
          if (!open_q && mode_i == bse_pkg::MODE_NULL) begin
            cmd_o.act      = bse_pkg::ACT_NULLSTR;
            cmd_o.null_len = (cap_q >= bse_pkg::FULL_NULL_CAP) ? bse_pkg::NULL_LEN
                                                             : 3'(cap_q - bse_pkg::MIN_CAP);
          end else begin
            cmd_o.act = bse_pkg::ACT_END;
          end
        end
        w_d     = 16'd0;
        open_d  = 1'b0;
        trunc_d = 1'b0;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  assign cmd_push_o = accept && emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q   <= 16'd0;
      w_q     <= 16'd0;
      open_q  <= 1'b0;
      trunc_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if (accept) begin
        w_q     <= w_d;
        open_q  <= open_d;
        trunc_q <= trunc_d;
      end
    end
  end

endmodule

[sv/bse_back.sv]
// back end: expands queued commands into output bytes, one per cycle while the output is not stalled
`timescale 1ns / 1ps
`include "bounded_string_escaper_defines.svh"
module bse_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  input  bse_pkg::cmd_t cmd_i,
  output logic          cmd_pop_o,
  input  logic          out_pop_i,
  output logic          out_empty_o,
  output logic [7:0]    out_byte_o,
  output logic          is_last_o,
  output logic          nothing_written_o
);

  logic [3:0] step_q, step_d;
  logic [3:0] len;
  logic [3:0] q;
  logic       last_step;
  logic       ld;
  logic [7:0] byte_c;
  logic       last_c, none_c;

  logic       out_valid_q;
  logic [7:0] byte_q;
  logic       last_q, none_q;

  always_comb begin
    case (cmd_i.act)
      bse_pkg::ACT_PLAIN:   len = 4'd1;
      bse_pkg::ACT_PAIR:    len = 4'd2;
      bse_pkg::ACT_HEX:     len = 4'd4;
      bse_pkg::ACT_END:     len = 4'd2;
      bse_pkg::ACT_NULLSTR: len = {1'b0, cmd_i.null_len} + 4'd2;
      bse_pkg::ACT_NUL:     len = 4'd1;
      bse_pkg::ACT_EMPTY:   len = 4'd1;
      default:              len = 4'd0;
    endcase
    len = len + {3'd0, cmd_i.open};
  end

  assign q         = step_q - {3'd0, cmd_i.open};
  assign last_step = (step_q == len - 4'd1);

  always_comb begin
    byte_c = bse_pkg::CH_NUL;
    last_c = 1'b0;
    none_c = 1'b0;
    if (cmd_i.open && step_q == 4'd0) begin
      byte_c = bse_pkg::CH_QUOTE;
    end else begin
      case (cmd_i.act)
        bse_pkg::ACT_PLAIN: byte_c = cmd_i.data;
        bse_pkg::ACT_PAIR:  byte_c = (q == 4'd0) ? bse_pkg::CH_BSLASH : cmd_i.data;
        bse_pkg::ACT_HEX: begin
          case (q[1:0])
            2'd0:    byte_c = bse_pkg::CH_BSLASH;
            2'd1:    byte_c = bse_pkg::CH_LOW_X;
            2'd2:    byte_c = bse_pkg::hex_digit(cmd_i.data[7:4]);
            default: byte_c = bse_pkg::hex_digit(cmd_i.data[3:0]);
          endcase
        end
        bse_pkg::ACT_END: begin
          byte_c = (q == 4'd0) ? bse_pkg::CH_QUOTE : bse_pkg::CH_NUL;
          last_c = (q != 4'd0);
        end
        bse_pkg::ACT_NULLSTR: begin
          if (q < {1'b0, cmd_i.null_len}) begin
            byte_c = bse_pkg::null_char(q[2:0]);
          end else if (q == {1'b0, cmd_i.null_len}) begin
            byte_c = bse_pkg::CH_QUOTE;
          end else begin
            last_c = 1'b1;
          end
        end
        bse_pkg::ACT_NUL: last_c = 1'b1;
        bse_pkg::ACT_EMPTY: begin
          last_c = 1'b1;
          none_c = 1'b1;
        end
        default: byte_c = bse_pkg::CH_NUL;
      endcase
    end
  end

  // output register takes a new byte whenever a command is queued and it is free or being drained
  assign ld        = cmd_valid_i && (!out_valid_q || out_pop_i);
  assign cmd_pop_o = ld && last_step;

  always_comb begin
    step_d = step_q;
    if (ld) begin
      step_d = last_step ? 4'd0 : step_q + 4'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= 4'd0;
      out_valid_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      out_valid_q <= ld || (out_valid_q && !out_pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld) begin
      byte_q <= byte_c;
      last_q <= last_c;
      none_q <= none_c;
    end
  end

  assign out_empty_o       = !out_valid_q;
  assign out_byte_o        = byte_q;
  assign is_last_o         = last_q;
  assign nothing_written_o = none_q;

  `BSE_ASSERT(a_step_in_cmd, clk_i, rst_ni, cmd_valid_i |-> step_q < len)
  `BSE_ASSERT(a_none_last, clk_i, rst_ni, out_valid_q && none_q |-> last_q && byte_q == bse_pkg::CH_NUL)
  `BSE_ASSERT(a_last_restart, clk_i, rst_ni, ld && last_c |=> step_q == 4'd0)

endmodule
